### rtl/sflt_pkg.sv
package sflt_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int SIZE_BITS   = 32;
    localparam int MAX_FREE    = 64;
    localparam int CLASS_COUNT = 12;
    localparam int CLS_BITS    = 4;
    localparam logic [CLS_BITS-1:0] TOP_CLASS = CLS_BITS'(CLASS_COUNT - 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_NOFIT   = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [ADDR_BITS-1:0] block_addr;
        logic [SIZE_BITS-1:0] block_size;
    } t_in;

    typedef struct packed {
        logic [2:0]           status;
        logic [ADDR_BITS-1:0] found_addr;
        logic [SIZE_BITS-1:0] found_size;
    } t_out;

    // Class k holds sizes up to 16 << k; anything above 16384 is the top class.
    function automatic logic [CLS_BITS-1:0] sflt_class(input logic [SIZE_BITS-1:0] size);
        logic [CLS_BITS-1:0] cls;
        cls = TOP_CLASS;
        for (int k = CLASS_COUNT - 2; k >= 0; k--) begin
            if (size <= (SIZE_BITS'(16) << k)) begin
                cls = CLS_BITS'(k);
            end
        end
        return cls;
    endfunction

endpackage

### rtl/sflt_ram.sv
module sflt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/segregated_free_list_table.sv
// Free-block table with segregated size classes.
// Input channel: i_valid / o_stall carry one t_in item (insert, remove or find).
// Output channel: o_valid / i_stall carry one t_out result for every item.
// One item is worked at a time; o_stall is high from acceptance until the
// result has been loaded into the output register.
// Work per item is set by a single read port on the entry memory, swept one
// entry a cycle through one shared compare unit:
//   find                 : one search sweep
//   insert / remove hit  : a search sweep, then a rank update sweep
//   insert / remove miss : one search sweep
//   unused opcode        : no sweep
// The output register frees the input side: a new item is taken while a
// result still waits. If the receiver stalls, the next result holds in the
// block until the output register empties.
// Reset (synchronous, active low) empties the table at once through the valid
// bits and drops any pending result; no clearing sweep is needed.
module segregated_free_list_table #(
    parameter int MAX_FREE = sflt_pkg::MAX_FREE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sflt_pkg::t_in i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output sflt_pkg::t_out o_res
);
    import sflt_pkg::*;

    localparam int IW = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int RW = IW;
    localparam int KW = IW + 1;
    localparam int EW = ADDR_BITS + SIZE_BITS + RW;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE, S_FINISH} t_state;

    t_state               r_state;
    t_in                  r_item;
    logic [CLS_BITS-1:0]  r_rcls;
    logic [MAX_FREE-1:0]  r_valid;
    logic [KW-1:0]        r_rd_k;
    logic                 r_chk;
    logic [IW-1:0]        r_chk_idx;
    logic                 r_hit;
    logic                 r_dup;
    logic                 r_have_slot;
    logic [IW-1:0]        r_slot;
    logic [RW-1:0]        r_rank;
    logic [CLS_BITS-1:0]  r_bcls;
    logic [ADDR_BITS-1:0] r_bkey;
    logic [ADDR_BITS-1:0] r_baddr;
    logic [SIZE_BITS-1:0] r_bsize;
    logic [2:0]           r_status;

    logic                 issue;
    logic                 pass_done;
    logic [EW-1:0]        rd_data;
    logic                 p_valid;
    logic [ADDR_BITS-1:0] p_addr;
    logic [SIZE_BITS-1:0] p_size;
    logic [RW-1:0]        p_rec;
    logic [CLS_BITS-1:0]  p_cls;
    logic [ADDR_BITS-1:0] p_key;
    logic                 p_elig;
    logic                 p_better;
    logic                 wr_en;
    logic [EW-1:0]        wr_data;

    sflt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FREE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_chk_idx),
        .i_wdata (wr_data),
        .i_raddr (r_rd_k[IW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign issue     = (r_rd_k != KW'(MAX_FREE));
    assign pass_done = !issue && !r_chk;

    assign p_valid = r_valid[r_chk_idx];
    assign p_rec   = rd_data[RW-1:0];
    assign p_size  = rd_data[RW +: SIZE_BITS];
    assign p_addr  = rd_data[RW + SIZE_BITS +: ADDR_BITS];
    assign p_cls   = sflt_class(p_size);

    // The shared compare: lower class wins, then the newest block (lowest
    // rank) in the lower classes or the lowest address in the top class.
    always_comb begin
        p_key    = (p_cls == TOP_CLASS) ? p_addr : ADDR_BITS'(p_rec);
        p_elig   = p_valid && (p_cls >= r_rcls) && (p_size >= r_item.block_size);
        p_better = !r_hit || (p_cls < r_bcls) || ((p_cls == r_bcls) && (p_key < r_bkey));
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = {p_addr, p_size, p_rec + RW'(1)};
        if (r_state == S_UPDATE && r_chk) begin
            if (r_item.opcode == OP_INSERT) begin
                if (r_chk_idx == r_slot) begin
                    wr_en   = 1'b1;
                    wr_data = {r_item.block_addr, r_item.block_size, RW'(0)};
                end else if (p_valid) begin
                    wr_en = 1'b1;
                end
            end else begin
                wr_en   = p_valid && (p_rec > r_rank);
                wr_data = {p_addr, p_size, p_rec - RW'(1)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_chk   <= 1'b0;
            r_rd_k  <= '0;
            o_valid <= 1'b0;
        end else begin
            // The finishing state loads the output register itself.
            if (o_valid && !i_stall && r_state != S_FINISH) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item      <= i_item;
                        r_rcls      <= sflt_class(i_item.block_size);
                        r_hit       <= 1'b0;
                        r_dup       <= 1'b0;
                        r_have_slot <= 1'b0;
                        r_rd_k      <= '0;
                        r_chk       <= 1'b0;
                        r_status    <= ST_OK;
                        r_state     <= (i_item.opcode == OP_NONE) ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_chk     <= issue;
                    r_chk_idx <= r_rd_k[IW-1:0];
                    if (issue) begin
                        r_rd_k <= r_rd_k + KW'(1);
                    end
                    if (r_chk) begin
                        unique case (r_item.opcode)
                            OP_INSERT: begin
                                if (p_valid && p_addr == r_item.block_addr) begin
                                    r_dup <= 1'b1;
                                end
                                if (!p_valid && !r_have_slot) begin
                                    r_have_slot <= 1'b1;
                                    r_slot      <= r_chk_idx;
                                end
                            end
                            OP_REMOVE: begin
                                if (p_valid && p_addr == r_item.block_addr) begin
                                    r_hit  <= 1'b1;
                                    r_slot <= r_chk_idx;
                                    r_rank <= p_rec;
                                end
                            end
                            OP_FIND: begin
                                if (p_elig && p_better) begin
                                    r_hit   <= 1'b1;
                                    r_bcls  <= p_cls;
                                    r_bkey  <= p_key;
                                    r_baddr <= p_addr;
                                    r_bsize <= p_size;
                                end
                            end
                            OP_NONE: begin
                            end
                        endcase
                    end
                    if (pass_done) begin
                        r_rd_k <= '0;
                        unique case (r_item.opcode)
                            OP_INSERT: begin
                                if (r_dup) begin
                                    r_status <= ST_PRESENT;
                                    r_state  <= S_FINISH;
                                end else if (!r_have_slot) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_state <= S_UPDATE;
                                end
                            end
                            OP_REMOVE: begin
                                if (!r_hit) begin
                                    r_status <= ST_ABSENT;
                                    r_state  <= S_FINISH;
                                end else begin
                                    r_valid[r_slot] <= 1'b0;
                                    r_state         <= S_UPDATE;
                                end
                            end
                            OP_FIND: begin
                                r_status <= r_hit ? ST_OK : ST_NOFIT;
                                r_state  <= S_FINISH;
                            end
                            OP_NONE: begin
                                r_status <= ST_OK;
                                r_state  <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_UPDATE: begin
                    r_chk     <= issue;
                    r_chk_idx <= r_rd_k[IW-1:0];
                    if (issue) begin
                        r_rd_k <= r_rd_k + KW'(1);
                    end
                    if (r_chk && r_item.opcode == OP_INSERT && r_chk_idx == r_slot) begin
                        r_valid[r_chk_idx] <= 1'b1;
                    end
                    if (pass_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!o_valid || !i_stall) begin
                        o_valid          <= 1'b1;
                        o_res.status     <= r_status;
                        o_res.found_addr <= (r_item.opcode == OP_FIND && r_hit) ? r_baddr : '0;
                        o_res.found_size <= (r_item.opcode == OP_FIND && r_hit) ? r_bsize : '0;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A transfer into the block never touches the table on its own.
    a_idle_table_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_valid))
        else $error("table changed while idle");

    // Insert and remove each change at most one entry.
    a_one_entry_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> ($countones(r_valid ^ $past(r_valid)) <= 1))
        else $error("more than one entry changed in a cycle");

    // A result is only loaded from the finishing state.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid)) |-> ($past(r_state) == S_FINISH))
        else $error("result appeared outside the finishing state");

    // The read sweep never runs past the end of the table.
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_k <= KW'(MAX_FREE)))
        else $error("sweep counter past table end");

endmodule
